[hdl/pps_pkg.sv]
// pps_pkg: shared types, constants and tables of the pure pursuit steering core
// used by pps_cordic, pps_div and pure_pursuit_steering_core; depends on nothing

package pps_pkg;

	// default path storage depth
	localparam int PATH_DEPTH_DEF = 64;

	// register reset values
	localparam logic [30:0] CRUISE_RST = 31'd32768;
	localparam logic [30:0] GTOL_RST   = 31'd6554;
	localparam logic [30:0] LOOK_RST   = 31'd65536;
	localparam logic [14:0] HTOL_RST   = 15'd5215;

	typedef enum logic [2:0] {
		CFG_CRUISE    = 3'd0,
		CFG_GOAL_TOL  = 3'd1,
		CFG_LOOKAHEAD = 3'd2,
		CFG_HEAD_TOL  = 3'd3,
		CFG_GOAL_X    = 3'd4,
		CFG_GOAL_Y    = 3'd5,
		CFG_PATH_LEN  = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_ARRIVED = 2'd0,
		STAT_ROTATE  = 2'd1,
		STAT_TRACK   = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	// cordic datapath
	localparam int COR_W     = 38;
	localparam int COR_ZW    = 34;
	localparam int COR_STEPS = 24;
	localparam logic signed [COR_ZW-1:0] QUARTER_TURN = 34'sd1073741824;

	// 1/K of the cordic in Q16
	localparam logic signed [16:0] INV_GAIN_Q16 = 17'sd39797;

	// 0.001 in Q32.32
	localparam logic [63:0] DIST2_FLOOR = 64'd4294967;

	// rotated offset scale product and divider numerator
	localparam int PROD_W = 67;
	localparam int NUM_W  = PROD_W + 16;
	localparam int HI_W   = NUM_W - 64;

	// atan(2^-i) in 32-bit turns
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic                     vec;
		logic signed [COR_W-1:0]  x;
		logic signed [COR_W-1:0]  y;
		logic signed [15:0]       heading;
	} cor_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [COR_W-1:0]  x;
		logic signed [COR_W-1:0]  y;
		logic signed [15:0]       ang;
	} cor_rsp_t;

	typedef struct packed {
		logic [HI_W-1:0] hi;
		logic [63:0]     lo;
		logic [63:0]     den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

[hdl/pps_if.sv]
// pps_if: valid/ready channel interfaces of the pure pursuit steering core
// pose/load beats in, steering command beats out; no dependencies

interface pps_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [5:0]         point_index;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;

	modport source (output valid, cmd, point_index, pos_x, pos_y, heading, input ready);
	modport sink (input valid, cmd, point_index, pos_x, pos_y, heading, output ready);
endinterface

interface pps_rsp_if;
	logic               valid;
	logic               ready;
	logic [30:0]        linear_vel;
	logic signed [31:0] angular_vel;
	logic [1:0]         status;

	modport source (output valid, linear_vel, angular_vel, status, input ready);
	modport sink (input valid, linear_vel, angular_vel, status, output ready);
endinterface

[hdl/pps_cordic.sv]
// pps_cordic: iterative cordic, one micro-rotation per cycle, rotation or vectoring
// depends on pps_pkg for widths, the atan table and the request/response structs

module pps_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pps_pkg::cor_req_t req,
	output pps_pkg::cor_rsp_t rsp
);
	localparam int W  = pps_pkg::COR_W;
	localparam int ZW = pps_pkg::COR_ZW;

	logic signed [W-1:0]  x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, at, zh, z0, zr;
	logic [4:0]           cnt_q;
	logic                 busy_q, done_q, vec_q, zero_q, ccw;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = ZW'(pps_pkg::atan_turn(cnt_q));
	assign ccw = vec_q ? !(y_q > 0) : !z_q[ZW-1];

	assign zh = {{(ZW-32){req.heading[15]}}, req.heading, 16'h0};
	assign z0 = -zh;
	assign zr = z_q + ZW'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vec_q  <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			vec_q  <= req.vec;
			cnt_q  <= '0;
			zero_q <= req.vec && req.x == '0 && req.y == '0;
			if (req.vec) begin
				// pre-fold the left half plane
				if (req.x[W-1] && !req.y[W-1]) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= pps_pkg::QUARTER_TURN;
				end else if (req.x[W-1]) begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= -pps_pkg::QUARTER_TURN;
				end else begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= '0;
				end
			end else begin
				if (z0 > pps_pkg::QUARTER_TURN) begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= z0 - pps_pkg::QUARTER_TURN;
				end else if (z0 < -pps_pkg::QUARTER_TURN) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= z0 + pps_pkg::QUARTER_TURN;
				end else begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= z0;
				end
			end
		end else if (busy_q) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			if (cnt_q == 5'(pps_pkg::COR_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.ang  = zero_q ? 16'sd0 : zr[31:16];

endmodule

[hdl/pps_div.sv]
// pps_div: restoring divider, one quotient bit per cycle, saturation on overflow
// depends on pps_pkg for the request/response structs

module pps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pps_pkg::div_req_t req,
	output pps_pkg::div_rsp_t rsp
);
	logic [63:0] r_q, lo_q, q_q, den_q;
	logic [64:0] rr;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, sat_q, ge;

	assign rr = {r_q, lo_q[63]};
	assign ge = rr >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			lo_q   <= '0;
			q_q    <= '0;
			den_q  <= '0;
		end else if (start) begin
			den_q <= req.den;
			lo_q  <= req.lo;
			r_q   <= 64'(req.hi);
			q_q   <= '0;
			cnt_q <= '0;
			if (64'(req.hi) >= req.den) begin
				// quotient would not fit
				sat_q  <= 1'b1;
				done_q <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				sat_q  <= 1'b0;
				done_q <= 1'b0;
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			r_q  <= ge ? 64'(rr - {1'b0, den_q}) : rr[63:0];
			q_q  <= {q_q[62:0], ge};
			lo_q <= {lo_q[62:0], 1'b0};
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quo  = q_q;

endmodule

[hdl/pure_pursuit_steering_core.sv]
// pure_pursuit_steering_core: a load beat writes one path point and gives no result
// a control beat squares the tolerances, checks the goal, then reads and rotates each path
// point scanned, rescans the chosen point when no point qualifies, vectors the heading and
// divides (empty path: straight to the result); one beat in flight, paced by the shared 24-step
// cordic and the bit-serial divider; the result register frees the input side while a result waits
// arst_n resets registers to defaults; path memory is not reset (no clearing pass)

module pure_pursuit_steering_core #(
	parameter int PATH_DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	pps_req_if.sink       req,
	pps_rsp_if.source     rsp
);
	localparam int AW = $clog2(PATH_DEPTH);
	localparam int NW = $clog2(PATH_DEPTH + 1);
	localparam int W  = pps_pkg::COR_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TOL, ST_LA, ST_GOAL, ST_RD, ST_DIFF, ST_ROT,
		ST_VEC0, ST_VEC1, ST_MUL0, ST_MUL1, ST_DIV0, ST_DIV1, ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [30:0]        cruise_q, gtol_q, look_q;
	logic [14:0]        htol_q;
	logic signed [31:0] goalx_q, goaly_q;
	logic [6:0]         plen_q;

	// per-step working registers
	logic signed [31:0] rx_q, ry_q;
	logic signed [15:0] h_q;
	logic [NW-1:0]      n_q, n_comb;
	logic [AW-1:0]      idx_q, last_q, last_idx;
	logic               any_q, final_q;
	logic [63:0]        tol2_q, look2_q;
	logic signed [32:0] dx_q, dy_q, dx_mem, dy_mem;
	logic signed [W:0]  lat_sc_q;
	logic [35:0]        m2_q;
	logic [pps_pkg::PROD_W-1:0] prod_q;
	logic [1:0]         cnt_q;

	// result staging and output register
	logic [30:0]        res_lin_q, out_lin_q;
	logic signed [31:0] res_ang_q, out_ang_q;
	pps_pkg::status_t   res_stat_q, out_stat_q;
	logic               out_v_q, push;

	// path memory, x in the upper half
	logic [63:0] mem [PATH_DEPTH];
	logic [63:0] rd_q;
	logic        load_we;

	// squared distance pipeline
	logic [31:0] ma, mb;
	logic [63:0] sqa_s1, sqb_s1, d2_s2;
	logic [64:0] d2_sum;

	// shared units
	logic              cor_start, div_start;
	pps_pkg::cor_req_t cor_req;
	pps_pkg::cor_rsp_t cor_rsp;
	pps_pkg::div_req_t div_req;
	pps_pkg::div_rsp_t div_rsp;

	// step arithmetic
	logic                           ahead;
	logic signed [W+16:0]           lat_mul;
	logic [W:0]                     lat_mag;
	logic [34:0]                    m_cap;
	logic [48:0]                    pp0, pp1;
	logic [pps_pkg::NUM_W-1:0]      num;
	logic [15:0]                    err_mag;
	logic [63:0]                    cap, q_eff;
	logic                           lat_neg;

	assign req.ready = (state_q == ST_IDLE);
	assign load_we   = req.valid && req.ready && req.cmd == pps_pkg::CMD_LOAD
		&& 32'(req.point_index) < 32'(PATH_DEPTH);

	// clamp path length to the storage depth
	assign n_comb   = (32'(plen_q) > 32'(PATH_DEPTH)) ? NW'(PATH_DEPTH) : NW'(plen_q);
	assign last_idx = AW'(n_q - 1'b1);

	// offset of the stored point from the robot
	assign dx_mem = {rd_q[63], rd_q[63:32]} - {rx_q[31], rx_q};
	assign dy_mem = {rd_q[31], rd_q[31:0]} - {ry_q[31], ry_q};

	always_ff @(posedge clk) begin
		if (load_we)
			mem[AW'(req.point_index)] <= {req.pos_x, req.pos_y};
		rd_q <= mem[idx_q];
	end

	// |dx|^2 + |dy|^2 saturating, registered in sqa_s1/sqb_s1 and then d2_s2 after dx_q/dy_q settle
	assign ma     = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign mb     = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
	assign d2_sum = {1'b0, sqa_s1} + {1'b0, sqb_s1};

	always_ff @(posedge clk) begin
		sqa_s1 <= ma * ma;
		sqb_s1 <= mb * mb;
		d2_s2  <= d2_sum[64] ? '1 : d2_sum[63:0];
	end

	// cordic: rotate the offset into the robot frame, or vector the chosen one
	assign cor_start       = (state_q == ST_DIFF) || (state_q == ST_VEC0);
	assign cor_req.vec     = (state_q == ST_VEC0);
	assign cor_req.x       = (state_q == ST_VEC0) ? cor_rsp.x : W'(dx_mem);
	assign cor_req.y       = (state_q == ST_VEC0) ? cor_rsp.y : W'(dy_mem);
	assign cor_req.heading = h_q;

	pps_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	assign ahead = !cor_rsp.x[W-1];

	// lateral offset with the cordic gain removed, floor shift
	assign lat_mul = cor_rsp.y * pps_pkg::INV_GAIN_Q16;
	assign lat_neg = lat_sc_q[W];
	assign lat_mag = lat_neg ? (W+1)'(-lat_sc_q) : lat_sc_q;
	assign m_cap   = (lat_mag > (W+1)'(36'h400000000)) ? 35'h400000000 : lat_mag[34:0];

	// 2*|lat| * cruise in two partial products
	assign pp0 = m2_q[17:0] * cruise_q;
	assign pp1 = m2_q[35:18] * cruise_q;
	assign num = {prod_q, 16'h0};

	assign div_start   = (state_q == ST_DIV0);
	assign div_req.hi  = num[pps_pkg::NUM_W-1:64];
	assign div_req.lo  = num[63:0];
	assign div_req.den = d2_s2;

	pps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cap   = lat_neg ? 64'h80000000 : 64'h7FFFFFFF;
	assign q_eff = (div_rsp.sat || div_rsp.quo > cap) ? cap : div_rsp.quo;

	assign err_mag = cor_rsp.ang[15] ? 16'(-cor_rsp.ang) : cor_rsp.ang;

	assign push = (state_q == ST_DONE) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cruise_q   <= pps_pkg::CRUISE_RST;
			gtol_q     <= pps_pkg::GTOL_RST;
			look_q     <= pps_pkg::LOOK_RST;
			htol_q     <= pps_pkg::HTOL_RST;
			goalx_q    <= '0;
			goaly_q    <= '0;
			plen_q     <= '0;
			rx_q       <= '0;
			ry_q       <= '0;
			h_q        <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			last_q     <= '0;
			any_q      <= 1'b0;
			final_q    <= 1'b0;
			tol2_q     <= '0;
			look2_q    <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			lat_sc_q   <= '0;
			m2_q       <= '0;
			prod_q     <= '0;
			cnt_q      <= '0;
			res_lin_q  <= '0;
			res_ang_q  <= '0;
			res_stat_q <= pps_pkg::STAT_ARRIVED;
			out_v_q    <= 1'b0;
			out_lin_q  <= '0;
			out_ang_q  <= '0;
			out_stat_q <= pps_pkg::STAT_ARRIVED;
		end else begin
			if (cfg_wr_en) begin
				case (pps_pkg::cfg_idx_t'(cfg_index))
					pps_pkg::CFG_CRUISE:    cruise_q <= cfg_data[30:0];
					pps_pkg::CFG_GOAL_TOL:  gtol_q   <= cfg_data[30:0];
					pps_pkg::CFG_LOOKAHEAD: look_q   <= cfg_data[30:0];
					pps_pkg::CFG_HEAD_TOL:  htol_q   <= cfg_data[14:0];
					pps_pkg::CFG_GOAL_X:    goalx_q  <= cfg_data;
					pps_pkg::CFG_GOAL_Y:    goaly_q  <= cfg_data;
					pps_pkg::CFG_PATH_LEN:  plen_q   <= cfg_data[6:0];
					default: ;
				endcase
			end

			// output register
			if (rsp.ready)
				out_v_q <= 1'b0;
			if (push) begin
				out_v_q    <= 1'b1;
				out_lin_q  <= res_lin_q;
				out_ang_q  <= res_ang_q;
				out_stat_q <= res_stat_q;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.cmd == pps_pkg::CMD_STEP) begin
						rx_q      <= req.pos_x;
						ry_q      <= req.pos_y;
						h_q       <= req.heading;
						n_q       <= n_comb;
						res_lin_q <= '0;
						res_ang_q <= '0;
						if (n_comb == '0) begin
							res_stat_q <= pps_pkg::STAT_EMPTY;
							state_q    <= ST_DONE;
						end else begin
							// square the goal tolerance through the distance pipe
							dx_q    <= {2'b00, gtol_q};
							dy_q    <= '0;
							cnt_q   <= '0;
							state_q <= ST_TOL;
						end
					end
				end
				ST_TOL: begin
					if (cnt_q == 2'd2) begin
						tol2_q  <= d2_s2;
						dx_q    <= {2'b00, look_q};
						cnt_q   <= '0;
						state_q <= ST_LA;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LA: begin
					if (cnt_q == 2'd2) begin
						look2_q <= d2_s2;
						dx_q    <= {goalx_q[31], goalx_q} - {rx_q[31], rx_q};
						dy_q    <= {goaly_q[31], goaly_q} - {ry_q[31], ry_q};
						cnt_q   <= '0;
						state_q <= ST_GOAL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_GOAL: begin
					if (cnt_q == 2'd2) begin
						if (d2_s2 <= tol2_q) begin
							res_stat_q <= pps_pkg::STAT_ARRIVED;
							state_q    <= ST_DONE;
						end else begin
							idx_q   <= '0;
							any_q   <= 1'b0;
							final_q <= 1'b0;
							state_q <= ST_RD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RD: begin
					// point read lands in rd_q at this edge
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					dx_q    <= dx_mem;
					dy_q    <= dy_mem;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (cor_rsp.done) begin
						if (final_q) begin
							state_q <= ST_VEC0;
						end else if (ahead && d2_s2 >= look2_q) begin
							// first ahead point at or beyond the lookahead
							state_q <= ST_VEC0;
						end else if (idx_q == last_idx) begin
							// no carrot: last ahead point, else the last point
							final_q <= 1'b1;
							idx_q   <= (ahead || !any_q) ? last_idx : last_q;
							state_q <= ST_RD;
						end else begin
							if (ahead) begin
								any_q  <= 1'b1;
								last_q <= idx_q;
							end
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_VEC0: begin
					lat_sc_q <= lat_mul[W+16:16];
					state_q  <= ST_VEC1;
				end
				ST_VEC1: begin
					if (cor_rsp.done) begin
						if (err_mag > 16'(htol_q)) begin
							res_stat_q <= pps_pkg::STAT_ROTATE;
							res_ang_q  <= cor_rsp.ang[15] ? -32'sd32768 : 32'sd32768;
							state_q    <= ST_DONE;
						end else begin
							res_stat_q <= pps_pkg::STAT_TRACK;
							res_lin_q  <= cruise_q;
							if (d2_s2 > pps_pkg::DIST2_FLOOR) begin
								m2_q    <= {m_cap, 1'b0};
								state_q <= ST_MUL0;
							end else begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_MUL0: begin
					prod_q  <= pps_pkg::PROD_W'(pp0);
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					prod_q  <= prod_q + (pps_pkg::PROD_W'(pp1) << 18);
					state_q <= ST_DIV0;
				end
				ST_DIV0: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						res_ang_q <= lat_neg ? -$signed(q_eff[31:0]) : $signed(q_eff[31:0]);
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (push)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.linear_vel  = out_lin_q;
	assign rsp.angular_vel = out_ang_q;
	assign rsp.status      = out_stat_q;

`ifndef SYNTH
	// a result beat appears only when the sequencer hands one over
	a_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("result beat without a finished step");

	// the scan never runs past the clamped path length
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT |-> NW'(idx_q) < n_q)
		else $error("scan index beyond path length");

	// a waiting result is not overwritten by the next one
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_v_q && !rsp.ready |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");

	// rotate in place carries no forward speed
	a_rot_lin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == pps_pkg::STAT_ROTATE |-> rsp.linear_vel == '0)
		else $error("rotate command with forward speed");

	// tracking drives at the configured speed
	a_track_lin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == pps_pkg::STAT_TRACK |-> rsp.linear_vel == cruise_q)
		else $error("tracking speed differs from cruise speed");
`endif

endmodule
